// File: hdl/csa_pkg.sv
// ----------------------------------------------------------------------------
// Segment allocator package
// Widths, operation and status codes, the segment record and the command
// that the controller broadcasts along the row of table cells.
// ----------------------------------------------------------------------------
`default_nettype none

package csa_pkg;

  localparam int TOTAL_UNITS  = 1024;
  localparam int MAX_SEGMENTS = 64;

  localparam int SIZE_W  = $clog2(TOTAL_UNITS + 1);
  localparam int IDX_W   = $clog2(MAX_SEGMENTS);
  localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
  localparam int OWNER_W = 16;
  localparam int REQ_W   = 12;
  localparam int OFF_W   = 10;
  localparam int OP_W    = 3;
  localparam int ST_W    = 3;

  localparam logic [OP_W-1:0] OP_ALLOC    = 3'd0;
  localparam logic [OP_W-1:0] OP_FREE     = 3'd1;
  localparam logic [OP_W-1:0] OP_COALESCE = 3'd2;
  localparam logic [OP_W-1:0] OP_COMPACT  = 3'd3;
  localparam logic [OP_W-1:0] OP_RESET    = 3'd4;

  localparam logic [ST_W-1:0] ST_OK            = 3'd0;
  localparam logic [ST_W-1:0] ST_BAD_SIZE      = 3'd1;
  localparam logic [ST_W-1:0] ST_OWNER_EXISTS  = 3'd2;
  localparam logic [ST_W-1:0] ST_NO_FIT        = 3'd3;
  localparam logic [ST_W-1:0] ST_OWNER_MISSING = 3'd4;
  localparam logic [ST_W-1:0] ST_TABLE_FULL    = 3'd5;

  // One table entry. A cell whose live bit is clear is a hole.
  typedef struct packed {
    logic               live;
    logic               free;
    logic [SIZE_W-1:0]  size;
    logic [OWNER_W-1:0] owner;
  } seg_t;

  typedef enum logic [2:0] {
    CM_HOLD,
    CM_ROTATE,
    CM_SQUEEZE,
    CM_SPLIT,
    CM_TAKE,
    CM_RELEASE,
    CM_APPEND,
    CM_RESET
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t         mode;
    logic [IDX_W-1:0]   idx;
    logic [SIZE_W-1:0]  size;
    logic [OWNER_W-1:0] owner;
    logic               phase;
  } cell_cmd_t;

endpackage

`default_nettype wire

// File: hdl/csa_cell.sv
// ----------------------------------------------------------------------------
// Segment table cell
// Holds one table entry and updates it, partly from its neighbours, under the
// controller's command: rotate, hole squeeze, split, take, release, append, reset.
// ----------------------------------------------------------------------------
`default_nettype none

module csa_cell import csa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] cell_idx,
  input  cell_cmd_t        cmd,
  input  seg_t             left_seg,
  input  seg_t             right_seg,
  output seg_t             seg
);

  logic [IDX_W:0] my_pos;
  logic [IDX_W:0] cut_pos;
  logic           hit;

  assign my_pos  = {1'b0, cell_idx};
  assign cut_pos = {1'b0, cmd.idx} + (IDX_W + 1)'(1);
  assign hit     = (cell_idx == cmd.idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      seg.live <= (cell_idx == '0);
      seg.free <= 1'b1;
      seg.size <= SIZE_W'(TOTAL_UNITS);
    end else begin
      unique case (cmd.mode)
        CM_HOLD: begin
        end
        CM_ROTATE: begin
          seg <= right_seg;
        end
        CM_SQUEEZE: begin
          // Odd-even transposition: a hole swaps with a live right neighbour.
          if (cell_idx[0] == cmd.phase) begin
            if (!seg.live && right_seg.live) seg <= right_seg;
          end else begin
            if (!left_seg.live && seg.live) seg <= left_seg;
          end
        end
        CM_SPLIT: begin
          if (my_pos > cut_pos) begin
            seg <= left_seg;
          end else if (my_pos == cut_pos) begin
            seg <= '{live: 1'b1, free: 1'b1, size: left_seg.size - cmd.size,
                     owner: '0};
          end else if (hit) begin
            seg.size  <= cmd.size;
            seg.free  <= 1'b0;
            seg.owner <= cmd.owner;
          end
        end
        CM_TAKE: begin
          if (hit) begin
            seg.free  <= 1'b0;
            seg.owner <= cmd.owner;
          end
        end
        CM_RELEASE: begin
          if (hit) begin
            seg.free  <= 1'b1;
            seg.owner <= '0;
          end
        end
        CM_APPEND: begin
          if (hit) seg <= '{live: 1'b1, free: 1'b1, size: cmd.size, owner: '0};
        end
        CM_RESET: begin
          seg.live <= (cell_idx == '0);
          seg.free <= 1'b1;
          seg.size <= SIZE_W'(TOTAL_UNITS);
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/contiguous_segment_allocator.sv
// ----------------------------------------------------------------------------
// Contiguous segment allocator
// Address-ordered segment table over a pool of units, kept in a row of cells,
// with allocate, free, coalesce, compact and reset operations.
// ----------------------------------------------------------------------------
// Usage: an operation is taken on the input channel (in_valid/in_ready) only
// while the block is idle; its one result leaves on the output channel
// (out_valid/out_ready) from an output register, so the next operation may be
// taken while a result still waits for its transfer.
// The table rotates through the cell row past the controller, one entry per
// cycle, in passes over all cells and the rotation register. Each operation runs:
//   allocate and free: scan pass, update step on success, statistics pass;
//   allocate with a bad size and unused codes: statistics pass; reset:
//   update step, statistics pass; coalesce and compact: rewrite pass, hole
//   squeeze, update step for compact when needed, statistics pass.
// The user writes fit_policy through cfg_we/cfg_wdata only while the block is
// idle; the block does not enforce it. Reset (rst, synchronous) leaves one free
// segment over the whole pool and first-fit policy. A stalled receiver holds a
// finished result in the output register; the block waits to deliver the next one.
// ----------------------------------------------------------------------------
`default_nettype none

module contiguous_segment_allocator import csa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    op,
  input  logic [OWNER_W-1:0] owner_id,
  input  logic [REQ_W-1:0]   request_units,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ST_W-1:0]    status,
  output logic [OFF_W-1:0]   block_offset,
  output logic [SIZE_W-1:0]  used_units,
  output logic [SIZE_W-1:0]  free_units,
  output logic [SIZE_W-1:0]  largest_free,
  output logic [SIZE_W-1:0]  fragmented_units,
  output logic [CNT_W-1:0]   active_owners,
  output logic [CNT_W-1:0]   segment_total
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_MERGE, S_SQUEEZE, S_APPLY, S_STATS, S_DONE
  } state_t;

  localparam logic [CNT_W-1:0] PASS_LAST = CNT_W'(MAX_SEGMENTS);
  localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(MAX_SEGMENTS - 1);

  state_t             state;
  logic               fit_policy;
  logic [OP_W-1:0]    op_q;
  logic [OWNER_W-1:0] owner_q;
  logic [REQ_W-1:0]   req_q;
  logic [ST_W-1:0]    status_q;
  logic [OFF_W-1:0]   offset_q;
  logic [CNT_W-1:0]   seg_count;
  logic [CNT_W-1:0]   pass_cnt;
  seg_t               p_seg;
  seg_t               tail_seg;

  logic               found;
  logic               owner_hit;
  logic [IDX_W-1:0]   pick;
  logic [SIZE_W-1:0]  pick_size;
  logic [SIZE_W-1:0]  pick_pos;
  logic [SIZE_W-1:0]  pos;
  logic [SIZE_W-1:0]  m_spare;
  logic [CNT_W-1:0]   m_active;

  logic [SIZE_W-1:0]  st_used;
  logic [SIZE_W-1:0]  st_spare;
  logic [SIZE_W-1:0]  st_largest;
  logic [CNT_W-1:0]   st_active;
  logic [CNT_W-1:0]   st_cnt;

  cell_mode_t         apply_mode;
  logic [IDX_W-1:0]   apply_idx;
  logic [SIZE_W-1:0]  apply_size;
  cell_cmd_t          cmd;

  seg_t               segs [MAX_SEGMENTS];
  seg_t               cur;
  logic               merge_hit;
  logic               fit_ok;
  logic               better;
  logic               own_match;
  logic               pass_end;
  logic               sq_end;

  // Cell row: entry k sits in cell k between passes; a rotate pass moves the
  // row one cell to the head per cycle, through p_seg back into the tail.
  for (genvar gi = 0; gi < MAX_SEGMENTS; gi++) begin : g_cell
    seg_t left_s;
    seg_t right_s;
    if (gi == 0) begin : g_first
      // The head cell sees a live boundary on its left, so no hole enters it.
      assign left_s = '{live: 1'b1, free: 1'b0, size: '0, owner: '0};
    end else begin : g_left
      assign left_s = segs[gi-1];
    end
    if (gi == MAX_SEGMENTS - 1) begin : g_last
      assign right_s = tail_seg;
    end else begin : g_right
      assign right_s = segs[gi+1];
    end
    csa_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cell_idx  (IDX_W'(gi)),
      .cmd       (cmd),
      .left_seg  (left_s),
      .right_seg (right_s),
      .seg       (segs[gi])
    );
  end

  assign cur       = segs[0];
  assign merge_hit = cur.live && cur.free && p_seg.live && p_seg.free;
  assign fit_ok    = cur.live && cur.free && ({1'b0, cur.size} >= req_q);
  assign better    = !found || (fit_policy && (cur.size < pick_size));
  assign own_match = cur.live && !cur.free && (cur.owner == owner_q);
  assign pass_end  = (pass_cnt == PASS_LAST);
  assign sq_end    = (pass_cnt == SQ_LAST);
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    tail_seg = p_seg;
    if (state == S_SQUEEZE) begin
      tail_seg = '0;
    end else if (state == S_MERGE && op_q == OP_COALESCE && merge_hit) begin
      tail_seg = '0;
    end
  end

  always_comb begin
    cmd.idx   = apply_idx;
    cmd.size  = apply_size;
    cmd.owner = owner_q;
    cmd.phase = pass_cnt[0];
    unique case (state)
      S_SCAN, S_MERGE, S_STATS: cmd.mode = CM_ROTATE;
      S_SQUEEZE:                cmd.mode = CM_SQUEEZE;
      S_APPLY:                  cmd.mode = apply_mode;
      default:                  cmd.mode = CM_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy <= 1'b0;
    end else if (cfg_we) begin
      fit_policy <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      seg_count <= CNT_W'(1);
      pass_cnt  <= '0;
      p_seg     <= '0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q       <= op;
            owner_q    <= owner_id;
            req_q      <= request_units;
            status_q   <= ST_OK;
            offset_q   <= '0;
            pass_cnt   <= '0;
            p_seg      <= '0;
            found      <= 1'b0;
            owner_hit  <= 1'b0;
            pos        <= '0;
            m_spare    <= '0;
            m_active   <= '0;
            st_used    <= '0;
            st_spare   <= '0;
            st_largest <= '0;
            st_active  <= '0;
            st_cnt     <= '0;
            case (op)
              OP_ALLOC: begin
                if (request_units == '0 || request_units > REQ_W'(TOTAL_UNITS)) begin
                  status_q <= ST_BAD_SIZE;
                  state    <= S_STATS;
                end else begin
                  state <= S_SCAN;
                end
              end
              OP_FREE:                 state <= S_SCAN;
              OP_COALESCE, OP_COMPACT: state <= S_MERGE;
              OP_RESET: begin
                apply_mode <= CM_RESET;
                state      <= S_APPLY;
              end
              default:                 state <= S_STATS;
            endcase
          end
        end

        S_SCAN: begin
          pass_cnt <= pass_cnt + CNT_W'(1);
          p_seg    <= cur;
          if (op_q == OP_ALLOC) begin
            if (own_match) owner_hit <= 1'b1;
            if (fit_ok && better) begin
              found     <= 1'b1;
              pick      <= pass_cnt[IDX_W-1:0];
              pick_size <= cur.size;
              pick_pos  <= pos;
            end
            if (cur.live) pos <= pos + cur.size;
          end else if (own_match && !found) begin
            found <= 1'b1;
            pick  <= pass_cnt[IDX_W-1:0];
          end
          if (pass_end) begin
            pass_cnt   <= '0;
            apply_idx  <= pick;
            apply_size <= req_q[SIZE_W-1:0];
            state      <= S_STATS;
            if (op_q == OP_ALLOC) begin
              priority if (owner_hit) begin
                status_q <= ST_OWNER_EXISTS;
              end else if (!found) begin
                status_q <= ST_NO_FIT;
              end else if ({1'b0, pick_size} > req_q && seg_count == CNT_W'(MAX_SEGMENTS)) begin
                status_q <= ST_TABLE_FULL;
              end else begin
                apply_mode <= ({1'b0, pick_size} > req_q) ? CM_SPLIT : CM_TAKE;
                offset_q   <= pick_pos[OFF_W-1:0];
                state      <= S_APPLY;
              end
            end else if (found) begin
              apply_mode <= CM_RELEASE;
              state      <= S_APPLY;
            end else begin
              status_q <= ST_OWNER_MISSING;
            end
          end
        end

        S_MERGE: begin
          pass_cnt <= pass_cnt + CNT_W'(1);
          if (op_q == OP_COALESCE) begin
            // A free run collapses into its last entry; earlier ones become holes.
            if (merge_hit) p_seg.size <= p_seg.size + cur.size;
            else           p_seg <= cur;
          end else begin
            if (cur.live && cur.free) begin
              p_seg   <= '0;
              m_spare <= m_spare + cur.size;
            end else begin
              p_seg <= cur;
              if (cur.live) m_active <= m_active + CNT_W'(1);
            end
          end
          if (pass_end) begin
            pass_cnt <= '0;
            state    <= S_SQUEEZE;
          end
        end

        S_SQUEEZE: begin
          pass_cnt <= pass_cnt + CNT_W'(1);
          if (sq_end) begin
            pass_cnt <= '0;
            state    <= S_STATS;
            if (op_q == OP_COMPACT) begin
              if (m_active == '0) begin
                apply_mode <= CM_RESET;
                state      <= S_APPLY;
              end else if (m_spare != '0) begin
                apply_mode <= CM_APPEND;
                apply_idx  <= m_active[IDX_W-1:0];
                apply_size <= m_spare;
                state      <= S_APPLY;
              end
            end
          end
        end

        S_APPLY: begin
          state <= S_STATS;
        end

        S_STATS: begin
          pass_cnt <= pass_cnt + CNT_W'(1);
          p_seg    <= cur;
          if (cur.live) begin
            st_cnt <= st_cnt + CNT_W'(1);
            if (cur.free) begin
              st_spare <= st_spare + cur.size;
              if (cur.size > st_largest) st_largest <= cur.size;
            end else begin
              st_used   <= st_used + cur.size;
              st_active <= st_active + CNT_W'(1);
            end
          end
          if (pass_end) begin
            pass_cnt  <= '0;
            seg_count <= st_cnt;
            state     <= S_DONE;
          end
        end

        S_DONE: begin
          if (!out_valid || out_ready) begin
            status           <= status_q;
            block_offset     <= offset_q;
            used_units       <= st_used;
            free_units       <= st_spare;
            largest_free     <= st_largest;
            fragmented_units <= st_spare - st_largest;
            active_owners    <= st_active;
            segment_total    <= st_cnt;
            out_valid        <= 1'b1;
            state            <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_head_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> segs[0].live)
    else $error("table head is a hole while idle");

  a_tail_hole: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !p_seg.live)
    else $error("rotation register not empty while idle");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (seg_count != '0) && (seg_count <= CNT_W'(MAX_SEGMENTS)))
    else $error("segment count out of range");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!out_valid || out_ready)) |=> (out_valid && state == S_IDLE))
    else $error("finished result not presented");

  a_offset_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (block_offset == '0))
    else $error("offset reported on a failed operation");
`endif

endmodule

`default_nettype wire
